>>> rtl/cnco_pkg.sv
package cnco_pkg;

	// number of rotation cells in the chain (4..8; the angle table holds 8)
	localparam int ROTATION_STAGES = 8;
	localparam int STAGE_W         = $clog2(ROTATION_STAGES);

	localparam int ACC_W    = 20;
	localparam int PHASE_W  = 12;
	localparam int DATA_W   = 16;
	localparam int SAMPLE_W = 13;

	localparam logic signed [DATA_W-1:0] X_INIT    = 16'sd1242;
	localparam logic signed [DATA_W-1:0] HALF_TURN = 16'sd2048;
	localparam logic signed [DATA_W-1:0] QTR_TURN  = 16'sd1024;
	localparam logic signed [DATA_W-1:0] OFFSET    = 16'sd2048;

	// configuration register indexes
	typedef enum logic {
		CFG_FREQUENCY_WORD = 1'b0,
		CFG_OFFSET_MODE    = 1'b1
	} cfg_index_t;

	// one request in flight through the chain
	typedef struct packed {
		logic                     vld;
		logic                     neg;
		logic signed [DATA_W-1:0] x;
		logic signed [DATA_W-1:0] y;
		logic signed [DATA_W-1:0] a;
	} cnco_data_t;

	// arctangent of 2^-j in phase units (2048 = half a turn)
	function automatic logic signed [DATA_W-1:0] atan_step(input logic [STAGE_W-1:0] j);
		logic signed [DATA_W-1:0] r;
		case (int'(j))
			0:       r = 16'sd511;
			1:       r = 16'sd301;
			2:       r = 16'sd159;
			3:       r = 16'sd80;
			4:       r = 16'sd40;
			5:       r = 16'sd19;
			6:       r = 16'sd9;
			7:       r = 16'sd4;
			default: r = 16'sd0;
		endcase
		return r;
	endfunction

endpackage

>>> rtl/cnco_phase.sv
module cnco_phase
	import cnco_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  logic             take,
	input  logic             restart,
	input  logic [ACC_W-1:0] freq,
	output cnco_data_t       d_out
);

	logic [ACC_W-1:0]          acc_q;
	logic [ACC_W-1:0]          acc_cur;
	logic signed [PHASE_W-1:0] top;
	logic signed [DATA_W-1:0]  ph;
	logic signed [DATA_W-1:0]  ph_fold;
	logic                      neg;
	logic                      vld_s0;
	logic                      neg_s0;
	logic signed [DATA_W-1:0]  a_s0;

	assign acc_cur = restart ? '0 : acc_q;
	assign top     = acc_cur[ACC_W-1 -: PHASE_W];
	assign ph      = DATA_W'(top);

	// fold second and third quadrants by half a turn
	always_comb begin
		ph_fold = ph;
		neg     = 1'b0;
		if (ph >= QTR_TURN) begin
			ph_fold = ph - HALF_TURN;
			neg     = 1'b1;
		end else if (ph < -QTR_TURN) begin
			ph_fold = ph + HALF_TURN;
			neg     = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			vld_s0 <= 1'b0;
		end else begin
			if (take)
				acc_q <= acc_cur + freq;
			if (adv)
				vld_s0 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && take) begin
			neg_s0 <= neg;
			a_s0   <= ph_fold;
		end
	end

	assign d_out = '{vld: vld_s0, neg: neg_s0, x: X_INIT, y: '0, a: a_s0};

endmodule

>>> rtl/cnco_cell.sv
module cnco_cell
	import cnco_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic [STAGE_W-1:0] stage,
	input  cnco_data_t         d_in,
	output cnco_data_t         d_out
);

	logic signed [DATA_W-1:0] xs;
	logic signed [DATA_W-1:0] ys;
	logic signed [DATA_W-1:0] at;
	logic                     vld_q;
	cnco_data_t               nxt;
	cnco_data_t               pay_q;

	assign xs = d_in.x >>> stage;
	assign ys = d_in.y >>> stage;
	assign at = atan_step(stage);

	// one micro-rotation, direction from the sign of the residual angle
	always_comb begin
		nxt     = d_in;
		nxt.vld = d_in.vld;
		if (d_in.a >= 0) begin
			nxt.x = d_in.x - ys;
			nxt.y = d_in.y + xs;
			nxt.a = d_in.a - at;
		end else begin
			nxt.x = d_in.x + ys;
			nxt.y = d_in.y - xs;
			nxt.a = d_in.a + at;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= 1'b0;
		else if (adv)
			vld_q <= d_in.vld;
	end

	always_ff @(posedge clk) begin
		if (adv && d_in.vld)
			pay_q <= nxt;
	end

	always_comb begin
		d_out     = pay_q;
		d_out.vld = vld_q;
	end

endmodule

>>> rtl/cordic_nco_sine_cosine.sv
// Channel   | Dir | Signals                          | Carries
// ----------+-----+----------------------------------+-------------------------------
// s_axis    | in  | s_tvalid s_tready s_tdata[7:0]   | tick request: restart
// m_axis    | out | m_tvalid m_tready m_tdata[31:0]  | sample: cos_out, sin_out
// cfg       | in  | cfg_we cfg_index cfg_wdata[19:0] | frequency_word, offset_mode
//
// One request enters per clock while the output is not stalled. Each request passes
// a phase register, one register per rotation cell, then the output register.
// arst_n clears the phase accumulator, both config registers and all valid bits.
// The whole chain advances only while the output register is empty or being
// taken; a stalled output freezes every cell and drops s_tready.
module cordic_nco_sine_cosine
	import cnco_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [7:0]        s_tdata,   // [0] restart, [7:1] zero
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [31:0]       m_tdata,   // [12:0] cos_out, [25:13] sin_out, [31:26] zero
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [ACC_W-1:0]  cfg_wdata
);

	logic [ACC_W-1:0]      freq_q;
	logic                  offset_q;
	logic                  adv;
	logic                  take;
	cnco_data_t            chain [ROTATION_STAGES+1];
	cnco_data_t            last;
	logic signed [DATA_W-1:0] bias;
	logic signed [DATA_W-1:0] xo;
	logic signed [DATA_W-1:0] yo;
	logic                  m_tvalid_q;
	logic [SAMPLE_W-1:0]   cos_q;
	logic [SAMPLE_W-1:0]   sin_q;

	// config registers; must be written only while idle, a rule on the user that the block does not enforce
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_q   <= '0;
			offset_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_FREQUENCY_WORD: freq_q   <= cfg_wdata;
				CFG_OFFSET_MODE:    offset_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// global advance: output slot free or emptied this cycle
	assign adv      = !m_tvalid_q || m_tready;
	assign s_tready = adv;
	assign take     = s_tvalid && adv;

	cnco_phase u_phase (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.take    (take),
		.restart (s_tdata[0]),
		.freq    (freq_q),
		.d_out   (chain[0])
	);

	for (genvar g = 0; g < ROTATION_STAGES; g++) begin : g_cell
		cnco_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.adv    (adv),
			.stage  (STAGE_W'(g)),
			.d_in   (chain[g]),
			.d_out  (chain[g+1])
		);
	end

	assign last = chain[ROTATION_STAGES];

	// unfold and optional offset-binary bias
	assign bias = offset_q ? OFFSET : '0;
	assign xo   = (last.neg ? -last.x : last.x) + bias;
	assign yo   = (last.neg ? -last.y : last.y) + bias;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid_q <= 1'b0;
		else if (adv)
			m_tvalid_q <= last.vld;
	end

	always_ff @(posedge clk) begin
		if (adv && last.vld) begin
			cos_q <= xo[SAMPLE_W-1:0];
			sin_q <= yo[SAMPLE_W-1:0];
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {6'd0, sin_q, cos_q};

	// no request taken while the output is held
	a_no_take_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |-> !s_tready)
		else $error("request accepted during output stall");

	// folded phase entering the chain stays within a quarter turn
	a_fold_range: assert property (@(posedge clk) disable iff (!arst_n)
		chain[0].vld |-> (chain[0].a >= -QTR_TURN && chain[0].a < QTR_TURN))
		else $error("phase fold out of range");

	// a new sample only appears when the last cell held one
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(last.vld))
		else $error("output valid without source");

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps

// Sine/cosine oscillator bench.
// Ticks are queued by the stimulus process, then driven on the falling edge
// with random gaps. Each accepted tick is run through a local copy of the
// phase accumulator and the folded 8-cell rotation so that the expected
// cos/sin pair can be worked out. Samples leaving the block are checked
// field by field against the oldest expected pair.
module tb_top;
	import cnco_pkg::*;

	localparam int LATENCY     = ROTATION_STAGES + 2;
	localparam int CYCLE_LIMIT = 300000;
	localparam int REPORT_MAX  = 10;
	localparam int RAND_PHASES = 10;
	localparam int PHASE_TICKS = 70;

	// per-cell arctangent steps, cell 0 in the low 16 bits
	localparam logic [8*16-1:0] ATAN_STEPS = {16'd4, 16'd9, 16'd19, 16'd40,
		16'd80, 16'd159, 16'd301, 16'd511};

	typedef struct packed {
		logic [SAMPLE_W-1:0] cos_val;
		logic [SAMPLE_W-1:0] sin_val;
	} sample_t;

	logic              clk;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [7:0]        s_tdata;   // [0] restart, [7:1] zero
	logic              m_tvalid;
	logic              m_tready;
	logic [31:0]       m_tdata;   // [12:0] cos_out, [25:13] sin_out, [31:26] zero
	logic              cfg_we;
	logic              cfg_index;
	logic [ACC_W-1:0]  cfg_wdata;

	// restart flags still to be sent; front is the one on the bus
	logic    tick_q[$];
	// cos/sin pairs predicted but not yet seen at the output
	sample_t sample_q[$];

	// local copy of the oscillator state and its registers
	logic [ACC_W-1:0] nco_acc;
	logic [ACC_W-1:0] freq_word;
	logic             offset_on;

	logic    tick_taken;
	int      send_idle_pct;
	int      recv_idle_pct;
	int      fault_count;
	int      samples_checked;
	int      settings_used;
	int      restarts_sent;
	int      cycle_count;
	sample_t want;
	logic [ACC_W-1:0] acc_now;

	cordic_nco_sine_cosine uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Folded rotation for one sampled phase (upper 12 accumulator bits).
	// Second/third quadrant is swung by half a turn and the result negated.
	function automatic sample_t cordic_sample(input logic [PHASE_W-1:0] ph,
		input logic offset);
		logic signed [DATA_W-1:0] x;
		logic signed [DATA_W-1:0] y;
		logic signed [DATA_W-1:0] a;
		logic signed [DATA_W-1:0] xp;
		logic                     neg;
		sample_t                  r;
		int                       j;
		a = {{(DATA_W-PHASE_W){ph[PHASE_W-1]}}, ph};
		neg = 1'b0;
		if (a >= 16'sd1024) begin
			a = a - 16'sd2048;
			neg = 1'b1;
		end else if (a < -16'sd1024) begin
			a = a + 16'sd2048;
			neg = 1'b1;
		end
		x = 16'sd1242;
		y = 16'sd0;
		for (j = 0; j < ROTATION_STAGES && j < 8; j++) begin
			xp = x;
			if (a >= 0) begin
				x = xp - (y >>> j);
				y = y + (xp >>> j);
				a = a - $signed(ATAN_STEPS[j*16 +: 16]);
			end else begin
				x = xp + (y >>> j);
				y = y - (xp >>> j);
				a = a + $signed(ATAN_STEPS[j*16 +: 16]);
			end
		end
		if (neg) begin
			x = -x;
			y = -y;
		end
		if (offset) begin
			x = x + 16'sd2048;
			y = y + 16'sd2048;
		end
		r.cos_val = x[SAMPLE_W-1:0];
		r.sin_val = y[SAMPLE_W-1:0];
		return r;
	endfunction

	task automatic note_fault(input string what, input logic [SAMPLE_W-1:0] exp_v,
		input logic [SAMPLE_W-1:0] got_v);
		fault_count++;
		if (fault_count <= REPORT_MAX)
			$display("%0t: %s expected %0d (0x%h) got %0d (0x%h)", $realtime, what,
				$signed(exp_v), exp_v, $signed(got_v), got_v);
	endtask

	// Monitor: checks the sample leaving the block, then predicts for the
	// request entering it. Output check comes first, though with the pipeline
	// depth the two can never refer to the same request.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nco_acc    <= '0;
			freq_word  <= '0;
			offset_on  <= 1'b0;
			tick_taken <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (sample_q.size() == 0) begin
					note_fault("unexpected sample, cos_out", '0, m_tdata[12:0]);
				end else begin
					want = sample_q.pop_front();
					samples_checked++;
					if (m_tdata[12:0] !== want.cos_val)
						note_fault("cos_out", want.cos_val, m_tdata[12:0]);
					if (m_tdata[25:13] !== want.sin_val)
						note_fault("sin_out", want.sin_val, m_tdata[25:13]);
				end
			end
			tick_taken <= s_tvalid && s_tready;
			if (s_tvalid && s_tready) begin
				// restart clears the accumulator before the sample is taken
				acc_now = s_tdata[0] ? '0 : nco_acc;
				sample_q.push_back(cordic_sample(acc_now[ACC_W-1 -: PHASE_W], offset_on));
				nco_acc <= acc_now + freq_word;
				void'(tick_q.pop_front());
				if (s_tdata[0])
					restarts_sent++;
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_FREQUENCY_WORD: freq_word <= cfg_wdata;
					CFG_OFFSET_MODE:    offset_on <= cfg_wdata[0];
				endcase
			end
		end
	end

	// Driver: holds a request until taken, otherwise offers the next one
	// after a random gap. Receiver stalls are drawn here too.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!s_tvalid || tick_taken) begin
				if (tick_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					s_tvalid <= 1'b1;
					s_tdata  <= {7'b0, tick_q[0]};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d samples outstanding", cycle_count,
				sample_q.size());
			$display("Mismatches found");
			$finish;
		end
	end

	// wait until nothing is queued or in flight, then let the chain settle
	task automatic wait_drained();
		while (tick_q.size() != 0 || sample_q.size() != 0 || s_tvalid)
			@(posedge clk);
		repeat (LATENCY + 2) @(posedge clk);
		@(negedge clk);
	endtask

	// one-cycle write pulse, after which cfg_we stays low until the task returns
	task automatic write_reg(input cfg_index_t idx, input logic [ACC_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we    <= 1'b0;
		@(negedge clk);
	endtask

	// waits for the block to go idle before the registers are written
	task automatic apply_settings(input logic [ACC_W-1:0] freq, input logic offset);
		wait_drained();
		write_reg(CFG_FREQUENCY_WORD, freq);
		write_reg(CFG_OFFSET_MODE, {{(ACC_W-1){1'b0}}, offset});
		settings_used++;
	endtask

	task automatic push_ticks(input int n, input int restart_pct);
		int i;
		for (i = 0; i < n; i++)
			tick_q.push_back($urandom_range(99) < restart_pct);
	endtask

	initial begin
		int               k;
		logic [ACC_W-1:0] fw;
		arst_n          = 1'b0;
		s_tvalid        = 1'b0;
		s_tdata         = '0;
		m_tready        = 1'b0;
		cfg_we          = 1'b0;
		cfg_index       = CFG_FREQUENCY_WORD;
		cfg_wdata       = '0;
		fault_count     = 0;
		samples_checked = 0;
		settings_used   = 0;
		restarts_sent   = 0;
		cycle_count     = 0;
		send_idle_pct   = 28;
		recv_idle_pct   = 62;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part.
		// Reset config: frequency zero, so both ticks sit at phase zero.
		tick_q.push_back(1'b0);
		tick_q.push_back(1'b1);
		// Quarter-turn steps: 0, +1024 (folds), -2048 (folds), -1024 (no fold).
		apply_settings(20'h40000, 1'b0);
		repeat (5) tick_q.push_back(1'b0);
		// Just past the negative fold edge, then near +half turn, offset on.
		apply_settings(20'hBFF00, 1'b1);
		tick_q.push_back(1'b1);
		tick_q.push_back(1'b0);
		tick_q.push_back(1'b0);
		// Just below the positive fold edge.
		apply_settings(20'h3FF00, 1'b0);
		tick_q.push_back(1'b1);
		tick_q.push_back(1'b0);
		tick_q.push_back(1'b0);
		// Largest step: accumulator wraps on every tick but the first after a restart; restart mid-run.
		apply_settings(20'hFFFFF, 1'b1);
		tick_q.push_back(1'b1);
		repeat (3) tick_q.push_back(1'b0);
		tick_q.push_back(1'b1);
		tick_q.push_back(1'b0);
		// Smallest non-zero step.
		apply_settings(20'h00001, 1'b0);
		tick_q.push_back(1'b1);
		tick_q.push_back(1'b0);

		// Random part: each phase waits for the block to empty before the
		// new settings go in, so the sender is paused until all samples are in.
		for (k = 0; k < RAND_PHASES; k++) begin
			case ($urandom_range(4))
				0:       fw = '0;
				1:       fw = '1;
				2:       fw = ACC_W'($urandom_range(4095, 1));
				default: fw = ACC_W'($urandom);
			endcase
			apply_settings(fw, 1'($urandom_range(1)));
			if (k < 4) begin
				send_idle_pct = 28;
				recv_idle_pct = 62;
			end else if (k < 7) begin
				send_idle_pct = 62;
				recv_idle_pct = 28;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			push_ticks(PHASE_TICKS, 4);
		end
		wait_drained();

		$display("Checked %0d samples over %0d register settings, %0d restarts",
			samples_checked, settings_used, restarts_sent);
		$display("Mismatching fields: %0d", fault_count);
		if (fault_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

>>> sim.f
rtl/cnco_pkg.sv
rtl/cnco_phase.sv
rtl/cnco_cell.sv
rtl/cordic_nco_sine_cosine.sv
tb/tb_top.sv
